// ===== hw/rtl/pcm_pkg.sv =====
// Shared types and constants of the pixel compositor.
`default_nettype none
package pcm_pkg;

	// Pixel and lane widths.
	localparam int PixelWidth = 32;
	localparam int LaneWidth  = 8;
	localparam int NumLanes   = PixelWidth / LaneWidth;

	// Configuration port.
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 32;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_MODE        = 2'd0,
		CFG_BLEND_LEVEL = 2'd1,
		CFG_FADE_COLOR  = 2'd2
	} cfg_index_t;

	// Compositing modes as written to the mode register.
	typedef enum logic [2:0] {
		MODE_MULTIPLY    = 3'd0,
		MODE_CONST_BLEND = 3'd1,
		MODE_ALPHA_BLEND = 3'd2,
		MODE_COLOR_FADE  = 3'd3,
		MODE_INVERT      = 3'd4
	} mode_t;

	// Per-lane operation carried down the pipeline.
	typedef enum logic [2:0] {
		OP_MUL  = 3'd0,
		OP_MIX  = 3'd1,
		OP_FADE = 3'd2,
		OP_INV  = 3'd3,
		OP_PASS = 3'd4
	} op_t;

	// Control that a lane needs for one pixel.
	typedef struct packed {
		op_t                  op;
		logic [LaneWidth-1:0] wt;
	} lane_ctrl_t;

	// Stage advance strobes handed to the lanes.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	localparam logic [LaneWidth-1:0] LaneMax    = 8'hff;
	localparam logic [LaneWidth:0]   WeightFull = 9'd256;
	localparam int                   AlphaLsb   = 24;

endpackage
`default_nettype wire

// ===== hw/rtl/pcm_cfg_regs.sv =====
// Configuration registers of the pixel compositor.
`default_nettype none
module pcm_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pcm_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [pcm_pkg::CfgDataWidth-1:0]    cfg_data,
	output pcm_pkg::mode_t                           mode,
	output logic [pcm_pkg::LaneWidth-1:0]            blend_level,
	output logic [pcm_pkg::PixelWidth-1:0]           fade_color
);

	logic [2:0]                        mode_q;
	logic [pcm_pkg::LaneWidth-1:0]     blend_level_q;
	logic [pcm_pkg::PixelWidth-1:0]    fade_color_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= '0;
			blend_level_q <= '0;
			fade_color_q  <= '0;
		end else if (cfg_we) begin
			unique case (pcm_pkg::cfg_index_t'(cfg_index))
				pcm_pkg::CFG_MODE:        mode_q        <= cfg_data[2:0];
				pcm_pkg::CFG_BLEND_LEVEL: blend_level_q <= cfg_data[pcm_pkg::LaneWidth-1:0];
				pcm_pkg::CFG_FADE_COLOR:  fade_color_q  <= cfg_data[pcm_pkg::PixelWidth-1:0];
				default: ;
			endcase
		end
	end

	assign mode        = pcm_pkg::mode_t'(mode_q);
	assign blend_level = blend_level_q;
	assign fade_color  = fade_color_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pcm_lane.sv =====
// One byte lane: operand selection and products, then combine and clamp.
`default_nettype none
module pcm_lane (
	input  wire logic                            clk,
	input  wire pcm_pkg::stage_en_t              en,
	input  wire pcm_pkg::lane_ctrl_t             ctrl,
	input  wire logic [pcm_pkg::LaneWidth-1:0]   d,
	input  wire logic [pcm_pkg::LaneWidth-1:0]   s,
	input  wire logic [pcm_pkg::LaneWidth-1:0]   c,
	output logic [pcm_pkg::LaneWidth-1:0]        result
);

	logic [pcm_pkg::LaneWidth-1:0] x0, x1, y1;
	logic [pcm_pkg::LaneWidth:0]   y0;
	logic [15:0]                   prod0;
	logic [15:0]                   prod1;
	logic [15:0]                   p0_s2, p1_s2;
	logic                          fade_s2;
	logic [15:0]                   sum_mix;
	logic [8:0]                    sum_fade;
	logic [pcm_pkg::LaneWidth-1:0] lane_res;
	logic [pcm_pkg::LaneWidth-1:0] result_s3;

	// Pick the two products that the operation needs.
	always_comb begin
		x0 = d;
		y0 = pcm_pkg::WeightFull;
		x1 = '0;
		y1 = '0;
		case (ctrl.op)
			pcm_pkg::OP_MUL: begin
				y0 = {1'b0, s};
			end
			pcm_pkg::OP_MIX: begin
				y0 = pcm_pkg::WeightFull - {1'b0, ctrl.wt};
				x1 = s;
				y1 = ctrl.wt;
			end
			pcm_pkg::OP_FADE: begin
				y0 = {1'b0, pcm_pkg::LaneMax - ctrl.wt};
				x1 = c;
				y1 = ctrl.wt;
			end
			pcm_pkg::OP_INV: begin
				x0 = pcm_pkg::LaneMax - d;
				y0 = {1'b0, ctrl.wt};
				x1 = d;
				y1 = pcm_pkg::LaneMax - ctrl.wt;
			end
			default: ;
		endcase
	end

	assign prod0 = 16'(x0) * 16'(y0);
	assign prod1 = 16'(x1) * 16'(y1);

	// Stage 2: products. The largest first product is 255 * 256 and fits 16 bits.
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			p0_s2   <= prod0;
			p1_s2   <= prod1;
			fade_s2 <= (ctrl.op == pcm_pkg::OP_FADE);
		end
	end

	// Fade scales each term on its own and saturates; the rest scale the sum.
	assign sum_mix  = p0_s2 + p1_s2;
	assign sum_fade = {1'b0, p0_s2[15:8]} + {1'b0, p1_s2[15:8]};

	always_comb begin
		if (fade_s2) begin
			lane_res = sum_fade[8] ? pcm_pkg::LaneMax : sum_fade[7:0];
		end else begin
			lane_res = sum_mix[15:8];
		end
	end

	// Stage 3: lane result.
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			result_s3 <= lane_res;
		end
	end

	assign result = result_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/pixel_compositor_modes.sv =====
// Top level of the four-lane RGBA pixel compositor.
//
//  channel  dir  handshake             payload
//  s        in   s_tvalid / s_tready   s_tdata: dest_pixel [31:0], src_pixel [63:32]
//  m        out  m_tvalid / m_tready   m_tdata: result_pixel [31:0]
//  cfg      in   cfg_we                cfg_index, cfg_data (mode, blend_level, fade_color)
//
// One pixel per clock while m_tready is high; a pixel passes stages 1 to 3 in order.
// Stage 1 registers the pixel and forms the blend weight (one 8x8 multiply),
// stage 2 forms an 8x9 and an 8x8 product per lane, stage 3 combines them into m_tdata.
// Each stage moves when the one after it is empty or moving, so bubbles close
// up and a stalled m side holds every word in place.
// Reset clears only the valid bits and the config registers; no clearing pass is needed.
`default_nettype none
module pixel_compositor_modes (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [63:0]                       s_tdata,  // dest_pixel, src_pixel
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [31:0]                            m_tdata,  // result_pixel
	input  wire logic                              cfg_we,
	input  wire logic [pcm_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [pcm_pkg::CfgDataWidth-1:0]  cfg_data
);

	localparam int LW = pcm_pkg::LaneWidth;
	localparam int PW = pcm_pkg::PixelWidth;

	pcm_pkg::mode_t      mode;
	logic [LW-1:0]       blend_level;
	logic [PW-1:0]       fade_color;

	logic                valid_s1, valid_s2, valid_s3;
	logic                en_s1;
	pcm_pkg::stage_en_t  stage_en;
	logic [PW-1:0]       d_s1, s_s1;
	pcm_pkg::op_t        op_s1;
	logic [LW-1:0]       wt_s1;
	pcm_pkg::op_t        op_in;
	logic [LW-1:0]       wt_in;
	logic [LW-1:0]       src_alpha;
	logic [2*LW-1:0]     alpha_prod;
	logic [PW-1:0]       result;

	pcm_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.blend_level (blend_level),
		.fade_color  (fade_color)
	);

	// Stage advance: a stage loads when it is empty or its word moves on.
	assign stage_en.en_s3 = !valid_s3 || m_tready;
	assign stage_en.en_s2 = !valid_s2 || stage_en.en_s3;
	assign en_s1          = !valid_s1 || stage_en.en_s2;
	assign s_tready       = en_s1;

	// Operation and weight for the incoming pixel.
	assign src_alpha  = s_tdata[PW+pcm_pkg::AlphaLsb +: LW];
	assign alpha_prod = 16'(src_alpha) * 16'(blend_level);

	always_comb begin
		op_in = pcm_pkg::OP_PASS;
		wt_in = blend_level;
		unique case (mode)
			pcm_pkg::MODE_MULTIPLY:    op_in = pcm_pkg::OP_MUL;
			pcm_pkg::MODE_CONST_BLEND: op_in = pcm_pkg::OP_MIX;
			pcm_pkg::MODE_ALPHA_BLEND: begin
				// Zero level keeps the destination; full level uses source alpha.
				if (blend_level == '0) begin
					op_in = pcm_pkg::OP_PASS;
				end else begin
					op_in = pcm_pkg::OP_MIX;
					wt_in = (blend_level == pcm_pkg::LaneMax) ? src_alpha
					                                          : alpha_prod[2*LW-1:LW];
				end
			end
			pcm_pkg::MODE_COLOR_FADE:  op_in = pcm_pkg::OP_FADE;
			pcm_pkg::MODE_INVERT:      op_in = pcm_pkg::OP_INV;
			default:                   op_in = pcm_pkg::OP_PASS;
		endcase
	end

	// Stage 1 data.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1  <= s_tdata[PW-1:0];
			s_s1  <= s_tdata[2*PW-1:PW];
			op_s1 <= op_in;
			wt_s1 <= wt_in;
		end
	end

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (stage_en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (stage_en.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Four byte lanes; invert leaves the alpha lane as it is.
	for (genvar k = 0; k < pcm_pkg::NumLanes; k++) begin : g_lane
		pcm_pkg::lane_ctrl_t ctrl;

		always_comb begin
			ctrl.wt = wt_s1;
			ctrl.op = op_s1;
			if (k == pcm_pkg::NumLanes - 1 && op_s1 == pcm_pkg::OP_INV) begin
				ctrl.op = pcm_pkg::OP_PASS;
			end
		end

		pcm_lane u_lane (
			.clk    (clk),
			.en     (stage_en),
			.ctrl   (ctrl),
			.d      (d_s1[k*LW +: LW]),
			.s      (s_s1[k*LW +: LW]),
			.c      (fade_color[k*LW +: LW]),
			.result (result[k*LW +: LW])
		);
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = result;

	// The input side only waits when every stage is full and the output stalls.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && !m_tready))
		else $error("input stalled with room in the pipeline");

	// An accepted word lands in stage 1.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word lost at stage 1");

	// A word in stage 2 moves to stage 3 when stage 3 advances.
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && stage_en.en_s3) |=> valid_s3)
		else $error("word lost between stage 2 and stage 3");

	// A blocked stage 1 word keeps its data.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !stage_en.en_s2) |=> (valid_s1 && $stable(d_s1) && $stable(s_s1)))
		else $error("stage 1 word changed while blocked");

endmodule
`default_nettype wire

// ===== sim/pixel_compositor_modes_tb.sv =====
// Self-checking testbench of the four-lane RGBA pixel compositor.
`timescale 1ns / 100ps

module pixel_compositor_modes_tb;

	localparam int          RandomItems = 1950;
	localparam int          CycleLimit  = 400000;
	localparam int          HoldCycles  = 400;
	localparam int          HoldAtFirst = 500;
	localparam int          HoldAtLater = 1400;
	localparam int          GapMax      = 12;
	localparam int          DirRows     = 22;
	localparam logic [1:0]  CfgIndexUnused = 2'd3;
	localparam logic [2:0]  ModeUnusedLo   = 3'd5;
	localparam logic [2:0]  ModeUnusedHi   = 3'd7;
	localparam logic [2:0]  ModeMul        = pcm_pkg::MODE_MULTIPLY;
	localparam logic [2:0]  ModeConst      = pcm_pkg::MODE_CONST_BLEND;
	localparam logic [2:0]  ModeAlpha      = pcm_pkg::MODE_ALPHA_BLEND;
	localparam logic [2:0]  ModeFade       = pcm_pkg::MODE_COLOR_FADE;
	localparam logic [2:0]  ModeInv        = pcm_pkg::MODE_INVERT;

	// One directed stimulus row: settings, input word and, where obvious, the result.
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  level;
		logic [31:0] fade;
		logic [31:0] dest;
		logic [31:0] src;
		logic        typed;
		logic [31:0] want;
	} dir_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [63:0]                       s_tdata;  // dest_pixel, src_pixel
	logic                              m_tvalid;
	logic                              m_tready;
	logic [31:0]                       m_tdata;  // result_pixel
	logic                              cfg_we;
	logic [pcm_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [pcm_pkg::CfgDataWidth-1:0]  cfg_data;

	// Shadow copy of the compositor registers.
	logic [2:0]  mode_q;
	logic [7:0]  level_q;
	logic [31:0] fade_q;

	logic [31:0] pending_results[$];
	dir_row_t    dir_rows [DirRows];
	int          mismatches = 0;
	int          cycles = 0;
	int          tx_gap_max;
	int          rx_gap_max;

	pixel_compositor_modes u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("pixel_compositor_modes_tb NOT OK");
			$finish;
		end
	end

	// Weighted mix of two lane values.
	function automatic int unsigned lane_mix(input int unsigned d, input int unsigned s,
			input int unsigned w);
		int unsigned v;
		v = (d * (256 - w) + s * w) >> 8;
		return v & 32'hff;
	endfunction

	// Composited pixel for the current register settings.
	function automatic logic [31:0] composite_pixel(input logic [31:0] d, input logic [31:0] s);
		logic [31:0] r;
		int unsigned a;
		int unsigned w;
		int unsigned dl;
		int unsigned sl;
		int unsigned cl;
		int unsigned v;
		r = d;
		a = level_q;
		w = 0;
		for (int k = 0; k < 4; k++) begin
			dl = d[8*k +: 8];
			sl = s[8*k +: 8];
			cl = fade_q[8*k +: 8];
			case (mode_q)
				pcm_pkg::MODE_MULTIPLY: begin
					v = (dl * sl) >> 8;
					r[8*k +: 8] = v[7:0];
				end
				pcm_pkg::MODE_CONST_BLEND: begin
					v = lane_mix(dl, sl, a);
					r[8*k +: 8] = v[7:0];
				end
				pcm_pkg::MODE_ALPHA_BLEND: begin
					// A zero level leaves the destination as it is.
					if (a != 0) begin
						w = s[31:24];
						if (a != 255)
							w = (w * a) >> 8;
						v = lane_mix(dl, sl, w);
						r[8*k +: 8] = v[7:0];
					end
				end
				pcm_pkg::MODE_COLOR_FADE: begin
					v = ((dl * (255 - a)) >> 8) + ((cl * a) >> 8);
					if (v > 255)
						v = 255;
					r[8*k +: 8] = v[7:0];
				end
				pcm_pkg::MODE_INVERT: begin
					// The alpha lane passes through.
					if (k < 3) begin
						v = ((255 - dl) * a + dl * (255 - a)) >> 8;
						r[8*k +: 8] = v[7:0];
					end
				end
				default: begin
					r = d;
				end
			endcase
		end
		return r;
	endfunction

	// Random pixel, biased toward whole-word and per-byte extremes.
	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		int          kind;
		kind = $urandom_range(5, 0);
		p = $urandom;
		if (kind == 1)
			p = 32'h0;
		else if (kind == 2)
			p = 32'hffffffff;
		else if (kind >= 4) begin
			for (int k = 0; k < 4; k++) begin
				case ($urandom_range(4, 0))
					0: p[8*k +: 8] = 8'h00;
					1: p[8*k +: 8] = 8'hff;
					2: p[8*k +: 8] = 8'h01;
					3: p[8*k +: 8] = 8'hfe;
					default: p[8*k +: 8] = 8'($urandom);
				endcase
			end
		end
		return p;
	endfunction

	// One register write; the caller lowers the write enable after the batch.
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			pcm_pkg::CFG_MODE:        mode_q  = data[2:0];
			pcm_pkg::CFG_BLEND_LEVEL: level_q = data[7:0];
			pcm_pkg::CFG_FADE_COLOR:  fade_q  = data;
			default:                  ;
		endcase
	endtask

	// Hold off the sender until every expected word has come out.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_pixel(input logic [31:0] d, input logic [31:0] s, input logic [31:0] want);
		int gap;
		bit taken;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {s, d};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		pending_results.push_back(want);
	endtask

	// Result side: random stalls, two long hold-offs, and the comparison.
	initial begin : result_sink
		int          gap;
		int          taken;
		bit          seen;
		logic [31:0] want;
		taken = 0;
		rx_gap_max = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (taken == HoldAtFirst || taken == HoldAtLater)
				gap = HoldCycles;
			else
				gap = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			seen = 1'b0;
			while (!seen) begin
				@(negedge clk);
				if (m_tvalid) begin
					seen = 1'b1;
					if (pending_results.size() == 0) begin
						$display("%0t: unexpected result_pixel, expected none, actual %08h",
							$time, m_tdata);
						mismatches++;
					end else begin
						want = pending_results.pop_front();
						if (m_tdata !== want) begin
							$display("%0t: result_pixel mismatch, expected %08h, actual %08h",
								$time, want, m_tdata);
							mismatches++;
						end
					end
				end
				@(posedge clk);
			end
			taken++;
			if (taken % 128 == 0)
				rx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : GapMax;
		end
	end

	// Reset, directed rows, random phases, and the final verdict.
	initial begin : stimulus
		logic [31:0] d;
		logic [31:0] s;
		logic [31:0] want;
		logic [2:0]  mode_pick;
		logic [7:0]  level_pick;
		logic [31:0] fade_pick;
		int          sent;
		int          phase_len;

		tx_gap_max = 0;
		mode_q     = pcm_pkg::MODE_MULTIPLY;
		level_q    = 8'h00;
		fade_q     = 32'h0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 64'h0;
		cfg_we    <= 1'b0;
		cfg_index <= pcm_pkg::CFG_MODE;
		cfg_data  <= 32'h0;

		dir_rows = '{
			'{ModeMul,      8'd0,   32'h0,        32'hffffffff, 32'hffffffff, 1'b1, 32'hfefefefe},
			'{ModeMul,      8'd0,   32'h0,        32'h00000000, 32'hffffffff, 1'b1, 32'h00000000},
			'{ModeMul,      8'd0,   32'h0,        32'h12345678, 32'h9abcdef0, 1'b0, 32'h0},
			'{ModeConst,    8'd0,   32'h0,        32'ha5c33c5a, 32'hffffffff, 1'b1, 32'ha5c33c5a},
			'{ModeConst,    8'd255, 32'h0,        32'h00000000, 32'hffffffff, 1'b0, 32'h0},
			'{ModeConst,    8'd128, 32'h0,        32'hff00ff00, 32'h00ff00ff, 1'b0, 32'h0},
			'{ModeAlpha,    8'd0,   32'h0,        32'h13579bdf, 32'hffffffff, 1'b1, 32'h13579bdf},
			'{ModeAlpha,    8'd255, 32'h0,        32'h00000000, 32'hffffffff, 1'b0, 32'h0},
			'{ModeAlpha,    8'd255, 32'h0,        32'hffffffff, 32'h00ffffff, 1'b1, 32'hffffffff},
			'{ModeAlpha,    8'd254, 32'h0,        32'h11223344, 32'h80aabbcc, 1'b0, 32'h0},
			'{ModeAlpha,    8'd1,   32'h0,        32'hffffffff, 32'hff000000, 1'b0, 32'h0},
			'{ModeFade,     8'd0,   32'hffffffff, 32'h00000000, 32'hffffffff, 1'b1, 32'h00000000},
			'{ModeFade,     8'd255, 32'hffffffff, 32'hffffffff, 32'h00000000, 1'b1, 32'hfefefefe},
			'{ModeFade,     8'd128, 32'h80ff0040, 32'hffffffff, 32'h00000000, 1'b0, 32'h0},
			'{ModeFade,     8'd77,  32'h00ff7f01, 32'h80402010, 32'h00000000, 1'b0, 32'h0},
			'{ModeInv,      8'd0,   32'h0,        32'hff000000, 32'h00000000, 1'b1, 32'hff000000},
			'{ModeInv,      8'd255, 32'h0,        32'h00ffffff, 32'h12345678, 1'b1, 32'h00000000},
			'{ModeInv,      8'd255, 32'h0,        32'h7f000000, 32'h00000000, 1'b1, 32'h7ffefefe},
			'{ModeInv,      8'd100, 32'h0,        32'h5a123456, 32'h00000000, 1'b0, 32'h0},
			'{ModeUnusedLo, 8'd40,  32'h0,        32'hdeadbeef, 32'h01234567, 1'b1, 32'hdeadbeef},
			'{ModeUnusedHi, 8'd255, 32'hffffffff, 32'h00000001, 32'hffffffff, 1'b1, 32'h00000001},
			'{ModeMul,      8'd255, 32'hffffffff, 32'h80808080, 32'h80808080, 1'b1, 32'h40404040}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the first ones run on the reset settings.
		tx_gap_max = GapMax;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != mode_q || dir_rows[i].level != level_q ||
					dir_rows[i].fade != fade_q) begin
				drain_pipeline();
				cfg_write(pcm_pkg::CFG_MODE, {29'h0, dir_rows[i].mode});
				cfg_write(pcm_pkg::CFG_BLEND_LEVEL, {24'h0, dir_rows[i].level});
				cfg_write(pcm_pkg::CFG_FADE_COLOR, dir_rows[i].fade);
				cfg_we <= 1'b0;
			end
			want = dir_rows[i].typed ? dir_rows[i].want
				: composite_pixel(dir_rows[i].dest, dir_rows[i].src);
			send_pixel(dir_rows[i].dest, dir_rows[i].src, want);
		end

		// Random phases, each on fresh settings written while the block is idle.
		sent = 0;
		while (sent < RandomItems) begin
			drain_pipeline();
			mode_pick = ($urandom_range(4, 0) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4, 0));
			case ($urandom_range(5, 0))
				0: level_pick = 8'd0;
				1: level_pick = 8'd1;
				2: level_pick = 8'd128;
				3: level_pick = 8'd254;
				4: level_pick = 8'd255;
				default: level_pick = 8'($urandom);
			endcase
			fade_pick = rand_pixel();
			// Bits above each register's width carry random junk.
			cfg_write(pcm_pkg::CFG_MODE, ($urandom & 32'hfffffff8) | {29'h0, mode_pick});
			cfg_write(pcm_pkg::CFG_BLEND_LEVEL,
				($urandom & 32'hffffff00) | {24'h0, level_pick});
			cfg_write(pcm_pkg::CFG_FADE_COLOR, fade_pick);
			if ($urandom_range(3, 0) == 0)
				cfg_write(CfgIndexUnused, $urandom);
			cfg_we <= 1'b0;
			tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : GapMax;
			phase_len = $urandom_range(150, 20);
			for (int n = 0; n < phase_len; n++) begin
				d = rand_pixel();
				s = rand_pixel();
				send_pixel(d, s, composite_pixel(d, s));
				sent++;
			end
		end

		drain_pipeline();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("pixel_compositor_modes_tb OK");
		else
			$display("pixel_compositor_modes_tb NOT OK");
		$finish;
	end

endmodule
